/* src/vtdt_pkg.sv */
// shared constants and result layout for the vertex triple dedup table
package vtdt_pkg;

  localparam int VIDX_W = 10;
  localparam int VCNT_W = 11;
  localparam int OUT_W  = 24;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // result fields, last field in the lowest bits
  typedef struct packed {
    logic [VCNT_W-1:0] vertex_count;
    logic              table_full;
    logic              new_vertex;
    logic [VIDX_W-1:0] vertex_index;
  } out_item_t;

endpackage

/* src/vtdt_cell.sv */
// one table entry: holds a triple, compares it against the query
module vtdt_cell #(
  parameter int QW  = 48,
  parameter int CW  = 11,
  parameter int POS = 0
) (
  input  logic          clk,
  input  logic          append,
  input  logic [CW-1:0] count,
  input  logic [QW-1:0] query,
  output logic          hit
);
  import vtdt_pkg::*;

  logic [QW-1:0] entry;
  logic          occupied;

  assign occupied = count > CW'(POS);

  // the tail entry takes the query on append
  always_ff @(posedge clk) begin
    if (append && count == CW'(POS)) begin
      entry <= query;
    end
  end

  always_ff @(posedge clk) begin
    hit <= occupied && (entry == query);
  end

endmodule

/* src/vtdt_tree.sv */
// registered priority tree: lowest set hit bit and its index
module vtdt_tree #(
  parameter int N  = 1024,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic [N-1:0]  hit,
  output logic          found,
  output logic [IW-1:0] idx
);
  import vtdt_pkg::*;

  localparam int P = 1 << IW;

  logic          node_found [1:2*P-1];
  logic [IW-1:0] node_idx   [1:2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node_found[P+i] = hit[i];
    end else begin : g_pad
      assign node_found[P+i] = 1'b0;
    end
    assign node_idx[P+i] = IW'(i);
  end

  // left child wins, so the lowest index comes out on top
  for (genvar j = 1; j < P; j++) begin : g_node
    always_ff @(posedge clk) begin
      node_found[j] <= node_found[2*j] | node_found[2*j+1];
      node_idx[j]   <= node_found[2*j] ? node_idx[2*j] : node_idx[2*j+1];
    end
  end

  assign found = node_found[1];
  assign idx   = node_idx[1];

endmodule

/* src/vertex_triple_dedup_table_top.sv */
// Vertex triple dedup table: turns face corners (position, texcoord and normal
// indices) into an index buffer, keeping distinct triples in insertion order.
// A corner request passes these steps in order: acceptance, a compare of all
// entry cells against the corner, the registered priority tree that finds the
// lowest matching entry, and the result, emitted with an append on a miss
// once the output can take it. A clear request goes from acceptance straight
// to the result. One request is in flight at a time; the next is taken while
// the previous result waits on the output. A miss on a full table returns
// index 0 with table_full set.
module vertex_triple_dedup_table_top #(
  parameter int MAX_VERTICES    = 1024,
  parameter int ATTR_INDEX_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // position_index, texcoord_index, normal_index, zero fill
  input  logic [((3*ATTR_INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // vertex_index, new_vertex, table_full, vertex_count, zero fill
  output logic [vtdt_pkg::OUT_W-1:0] m_axis_tdata
);
  import vtdt_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int QW = 3 * ATTR_INDEX_BITS;
  localparam int TW = $clog2(IW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_TREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [QW-1:0] query;
  logic          is_clear;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [TW-1:0] timer;
  logic          out_valid;
  out_item_t     out_data;
  out_item_t     result;
  logic          append;
  logic          can_emit;

  logic [MAX_VERTICES-1:0] hit;
  logic                    found;
  logic [IW-1:0]           found_idx;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    vtdt_cell #(
      .QW (QW),
      .CW (CW),
      .POS(k)
    ) u_cell (
      .clk   (clk),
      .append(append),
      .count (count),
      .query (query),
      .hit   (hit[k])
    );
  end

  vtdt_tree #(
    .N (MAX_VERTICES),
    .IW(IW)
  ) u_tree (
    .clk  (clk),
    .hit  (hit),
    .found(found),
    .idx  (found_idx)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_data);
  assign can_emit      = !out_valid || m_axis_tready;

  always_comb begin
    result       = '0;
    append       = 1'b0;
    count_next   = count;
    if (is_clear) begin
      count_next = '0;
    end else if (found) begin
      result.vertex_index = VIDX_W'(found_idx);
      result.vertex_count = VCNT_W'(count);
    end else if (count == CW'(MAX_VERTICES)) begin
      result.table_full   = 1'b1;
      result.vertex_count = VCNT_W'(count);
    end else begin
      append              = (state == S_DONE) && can_emit;
      count_next          = count + 1'b1;
      result.vertex_index = VIDX_W'(count);
      result.new_vertex   = 1'b1;
      result.vertex_count = VCNT_W'(count_next);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == FUNC_CLEAR) ? S_DONE : S_CMP;
        end
      end
      S_CMP:  state_next = S_TREE;
      S_TREE: begin
        if (timer == TW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      timer     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CMP) begin
        timer <= TW'(IW);
      end else if (state == S_TREE) begin
        timer <= timer - 1'b1;
      end
      if (state == S_DONE && can_emit) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      query    <= s_axis_tdata[QW-1:0];
      is_clear <= (s_axis_tuser == FUNC_CLEAR);
    end
    if (state == S_DONE && can_emit) begin
      out_data <= result;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_VERTICES))
    else $error("entry count above table size");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    append |-> (count < CW'(MAX_VERTICES)) && !is_clear)
    else $error("append on full table or clear");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    append |=> count == $past(count) + 1'b1)
    else $error("append did not advance the count");

endmodule
